// File: rtl/fipm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fipm_pkg
// Shared types, reset values and the control store of the fall impact peak
// monitor.
// ----------------------------------------------------------------------------
package fipm_pkg;

	localparam int AccelW     = 20;
	localparam int RootW      = 10;
	localparam int ThreshW    = 20;
	localparam int ImpactW    = 4;
	localparam int HoldW      = 14;
	localparam int BlinkW     = 10;
	localparam int CfgIndexW  = 2;
	localparam int CfgDataW   = 20;
	localparam int StepW      = 3;
	localparam int SqrtCntW   = 4;
	localparam int SqrtIters  = 10;

	localparam logic [ThreshW-1:0] ThreshReset = ThreshW'(9400);
	localparam logic [ImpactW-1:0] ImpactReset = ImpactW'(5);
	localparam logic [HoldW-1:0]   HoldReset   = HoldW'(10000);
	localparam logic [BlinkW-1:0]  BlinkReset  = BlinkW'(500);

	typedef enum logic [CfgIndexW-1:0] {
		REG_IMPACT_THRESHOLD = 2'd0,
		REG_IMPACT_TICKS     = 2'd1,
		REG_HOLD_TICKS       = 2'd2,
		REG_BLINK_HALF       = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_START   = 2'd0,
		PH_ARMED   = 2'd1,
		PH_FALLING = 2'd2,
		PH_LANDED  = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_WAIT_IN,
		OP_SQRT,
		OP_TIMER,
		OP_PEAK,
		OP_PHASE,
		OP_LED,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		COND_NONE,
		COND_NO_INPUT,
		COND_SQRT_BUSY,
		COND_OUT_FULL
	} cond_t;

	typedef logic [StepW-1:0] step_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		logic  cond_always;
		step_t target;
	} ucode_word_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		op_t op;
	} ctrl_t;

	// Status from the datapath back to the sequencer.
	typedef struct packed {
		logic in_valid;
		logic sqrt_busy;
		logic out_full;
	} status_t;

	localparam step_t StepWait = StepW'(0);
	localparam step_t StepSqrt = StepW'(1);
	localparam step_t StepEmit = StepW'(6);

	// Control store: one word per step. A step jumps to its target when its
	// condition holds (or always, for the closing step), else falls through.
	function automatic ucode_word_t ucode_rom(input step_t step);
		ucode_word_t w;
		case (step)
			StepW'(0): w = '{op: OP_WAIT_IN, cond: COND_NO_INPUT, cond_always: 1'b0,
				target: StepWait};
			StepW'(1): w = '{op: OP_SQRT, cond: COND_SQRT_BUSY, cond_always: 1'b0,
				target: StepSqrt};
			StepW'(2): w = '{op: OP_TIMER, cond: COND_NONE, cond_always: 1'b0,
				target: StepWait};
			StepW'(3): w = '{op: OP_PEAK, cond: COND_NONE, cond_always: 1'b0,
				target: StepWait};
			StepW'(4): w = '{op: OP_PHASE, cond: COND_NONE, cond_always: 1'b0,
				target: StepWait};
			StepW'(5): w = '{op: OP_LED, cond: COND_NONE, cond_always: 1'b0,
				target: StepWait};
			StepW'(6): w = '{op: OP_EMIT, cond: COND_OUT_FULL, cond_always: 1'b0,
				target: StepEmit};
			default:   w = '{op: OP_NOP, cond: COND_NONE, cond_always: 1'b1,
				target: StepWait};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/fipm_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fipm_isqrt
// Digit-serial integer square root: one root bit per cycle, giving a ten-bit
// root for a 20-bit radicand.
// ----------------------------------------------------------------------------
module fipm_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fipm_pkg::AccelW-1:0]   radicand,
	output logic                          busy,
	output logic [fipm_pkg::RootW-1:0]    root
);
	import fipm_pkg::*;

	localparam int RemW = RootW + 2;

	logic [AccelW-1:0]   rad_q;
	logic [RemW-1:0]     rem_q;
	logic [RootW-1:0]    root_q;
	logic [SqrtCntW-1:0] cnt_q;
	logic [RemW+1:0]     shifted;
	logic [RemW+1:0]     trial;
	logic                fits;

	assign shifted = {rem_q, rad_q[AccelW-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign fits    = (shifted >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= SqrtCntW'(SqrtIters);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - SqrtCntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= {rad_q[AccelW-3:0], 2'b00};
			if (fits) begin
				rem_q <= RemW'(shifted - trial);
			end else begin
				rem_q <= shifted[RemW-1:0];
			end
			root_q <= {root_q[RootW-2:0], fits};
		end
	end

	// The last iteration completes on the edge that takes the count from one to
	// zero, so the caller may move on while the count is one.
	assign busy = (cnt_q > SqrtCntW'(1));
	assign root = root_q;

endmodule

// File: rtl/fipm_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fipm_sequencer
// Step counter over the control store, with conditional jumps on datapath
// status.
// ----------------------------------------------------------------------------
module fipm_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  fipm_pkg::status_t status,
	output fipm_pkg::ctrl_t   ctrl
);
	import fipm_pkg::*;

	step_t       step_q;
	step_t       step_next;
	ucode_word_t word;
	logic        cond_true;

	assign word = ucode_rom(step_q);

	always_comb begin
		case (word.cond)
			COND_NO_INPUT:  cond_true = !status.in_valid;
			COND_SQRT_BUSY: cond_true = status.sqrt_busy;
			COND_OUT_FULL:  cond_true = status.out_full;
			default:        cond_true = 1'b0;
		endcase
	end

	always_comb begin
		if (cond_true || word.cond_always) begin
			step_next = word.target;
		end else begin
			step_next = step_q + StepW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= StepWait;
		end else begin
			step_q <= step_next;
		end
	end

	assign ctrl.op = word.op;

endmodule

// File: rtl/fipm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fipm_datapath
// Configuration registers, monitor state and the result register, updated one
// micro-operation at a time.
// ----------------------------------------------------------------------------
module fipm_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fipm_pkg::ctrl_t                 ctrl,
	output fipm_pkg::status_t               status,
	input  logic                            cfg_we,
	input  logic [fipm_pkg::CfgIndexW-1:0]  cfg_index,
	input  logic [fipm_pkg::CfgDataW-1:0]   cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            free_fall,
	input  logic [fipm_pkg::AccelW-1:0]     accel_value,
	input  logic                            key_press,
	output logic                            sqrt_start,
	output logic [fipm_pkg::AccelW-1:0]     sqrt_radicand,
	input  logic                            sqrt_busy,
	input  logic [fipm_pkg::RootW-1:0]      sqrt_root,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [fipm_pkg::RootW-1:0]      display_value,
	output logic                            display_write,
	output logic                            led_red,
	output logic                            low_power,
	output logic [1:0]                      phase
);
	import fipm_pkg::*;

	// Configuration.
	logic [ThreshW-1:0] thresh_q;
	logic [ImpactW-1:0] impact_ticks_q;
	logic [HoldW-1:0]   hold_ticks_q;
	logic [BlinkW-1:0]  blink_half_q;

	// Monitor state.
	phase_t             phase_q;
	logic [ImpactW-1:0] above_count_q;
	logic               impact_seen_q;
	logic [HoldW-1:0]   hold_count_q;
	logic [BlinkW-1:0]  blink_count_q;
	logic [RootW-1:0]   peak_root_q;
	logic [RootW-1:0]   shown_peak_q;
	logic               tracking_q;
	logic               blinking_q;
	logic               holding_q;
	logic               led_level_q;

	// Current item and its pending result.
	logic               free_fall_q;
	logic [AccelW-1:0]  accel_q;
	logic               key_q;
	logic [RootW-1:0]   dval_q;
	logic               dwrite_q;

	// Result register.
	logic               out_valid_q;
	logic [RootW-1:0]   out_value_q;
	logic               out_write_q;
	logic               out_led_q;
	logic               out_low_power_q;
	logic [1:0]         out_phase_q;

	logic               in_xfer;
	logic               out_xfer;
	logic               out_full;
	logic               emit;
	logic [ImpactW-1:0] above_next;
	logic [RootW-1:0]   peak_next;

	assign in_ready = (ctrl.op == OP_WAIT_IN);
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid_q && out_ready;
	assign out_full = out_valid_q && !out_ready;
	assign emit     = (ctrl.op == OP_EMIT) && !out_full;

	assign sqrt_start    = in_xfer;
	assign sqrt_radicand = accel_value;

	assign status.in_valid  = in_valid;
	assign status.sqrt_busy = sqrt_busy;
	assign status.out_full  = out_full;

	always_comb begin
		if (accel_q > thresh_q) begin
			above_next = (above_count_q != '0) ? above_count_q - ImpactW'(1) : '0;
		end else begin
			above_next = impact_ticks_q;
		end
	end

	assign peak_next = (tracking_q && (sqrt_root > peak_root_q)) ? sqrt_root : peak_root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q       <= ThreshReset;
			impact_ticks_q <= ImpactReset;
			hold_ticks_q   <= HoldReset;
			blink_half_q   <= BlinkReset;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMPACT_THRESHOLD: thresh_q       <= cfg_data[ThreshW-1:0];
				REG_IMPACT_TICKS:     impact_ticks_q <= cfg_data[ImpactW-1:0];
				REG_HOLD_TICKS:       hold_ticks_q   <= cfg_data[HoldW-1:0];
				REG_BLINK_HALF:       blink_half_q   <= cfg_data[BlinkW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_START;
			above_count_q <= ImpactReset;
			impact_seen_q <= 1'b0;
			hold_count_q  <= HoldReset;
			blink_count_q <= BlinkReset;
			peak_root_q   <= '0;
			shown_peak_q  <= '0;
			tracking_q    <= 1'b0;
			blinking_q    <= 1'b0;
			holding_q     <= 1'b0;
			led_level_q   <= 1'b0;
		end else begin
			case (ctrl.op)
				OP_TIMER: begin
					if (blinking_q) begin
						above_count_q <= above_next;
						impact_seen_q <= (above_next == '0);
					end
					if (holding_q && (hold_count_q != '0)) begin
						hold_count_q <= hold_count_q - HoldW'(1);
					end
				end
				OP_PEAK: begin
					peak_root_q  <= peak_next;
					shown_peak_q <= peak_next;
				end
				OP_PHASE: begin
					case (phase_q)
						PH_START: begin
							phase_q <= PH_ARMED;
						end
						PH_ARMED: begin
							if (free_fall_q) begin
								phase_q <= PH_FALLING;
							end
						end
						PH_FALLING: begin
							blinking_q <= 1'b1;
							tracking_q <= !impact_seen_q;
							if (impact_seen_q) begin
								phase_q <= PH_LANDED;
							end
						end
						default: begin
							holding_q <= 1'b1;
							if ((hold_count_q == '0) || key_q) begin
								blinking_q    <= 1'b0;
								holding_q     <= 1'b0;
								hold_count_q  <= hold_ticks_q;
								peak_root_q   <= '0;
								impact_seen_q <= 1'b0;
								phase_q       <= PH_ARMED;
							end
						end
					endcase
				end
				OP_LED: begin
					if (blinking_q) begin
						if (blink_count_q <= BlinkW'(1)) begin
							led_level_q   <= !led_level_q;
							blink_count_q <= blink_half_q;
						end else begin
							blink_count_q <= blink_count_q - BlinkW'(1);
						end
					end else begin
						led_level_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Item registers and the pending display write.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			free_fall_q <= free_fall;
			accel_q     <= accel_value;
			key_q       <= key_press;
			dval_q      <= '0;
			dwrite_q    <= 1'b0;
		end else if (ctrl.op == OP_PHASE) begin
			case (phase_q)
				PH_START: begin
					dwrite_q <= 1'b1;
				end
				PH_FALLING: begin
					if (impact_seen_q) begin
						dwrite_q <= 1'b1;
						dval_q   <= shown_peak_q;
					end
				end
				PH_LANDED: begin
					if ((hold_count_q == '0) || key_q) begin
						dwrite_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_value_q     <= dval_q;
			out_write_q     <= dwrite_q;
			out_led_q       <= led_level_q;
			out_low_power_q <= (phase_q == PH_ARMED);
			out_phase_q     <= phase_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign display_value = out_value_q;
	assign display_write = out_write_q;
	assign led_red       = out_led_q;
	assign low_power     = out_low_power_q;
	assign phase         = out_phase_q;

endmodule

// File: rtl/fall_impact_peak_monitor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fall_impact_peak_monitor_top
// Fall impact peak monitor: one input item per 1 ms tick, one result per item.
// ----------------------------------------------------------------------------
// Usage: each input transfer (in_valid/in_ready) carries one tick with the
// free-fall flag, the raw acceleration and a key press. Each tick produces
// exactly one result transfer (out_valid/out_ready) with the display value,
// display write strobe, red LED level, low-power request and the phase.
// A microcoded sequencer handles one tick at a time: a step to take the
// item, a wait on the bit-serial square root (one root bit per cycle), the
// timer, peak, phase and LED update steps and a step to load the result
// register, then a step to return to the wait step. The next item is taken
// only after the previous one has been loaded into the result register. A
// waiting result does not block the next input transfer; the sequencer only
// stalls at its load step when the previous result is still untaken.
// Configuration writes (cfg_we) are registered directly and should be made
// while no tick is in flight. Reset puts the monitor in the start phase with
// the default thresholds and timers.
// ----------------------------------------------------------------------------
module fall_impact_peak_monitor_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fipm_pkg::CfgIndexW-1:0]  cfg_index,
	input  logic [fipm_pkg::CfgDataW-1:0]   cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            free_fall,
	input  logic [fipm_pkg::AccelW-1:0]     accel_value,
	input  logic                            key_press,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [fipm_pkg::RootW-1:0]      display_value,
	output logic                            display_write,
	output logic                            led_red,
	output logic                            low_power,
	output logic [1:0]                      phase
);
	import fipm_pkg::*;

	ctrl_t             ctrl;
	status_t           status;
	logic              sqrt_start;
	logic [AccelW-1:0] sqrt_radicand;
	logic              sqrt_busy;
	logic [RootW-1:0]  sqrt_root;

	fipm_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	fipm_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sqrt_radicand),
		.busy     (sqrt_busy),
		.root     (sqrt_root)
	);

	fipm_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.free_fall     (free_fall),
		.accel_value   (accel_value),
		.key_press     (key_press),
		.sqrt_start    (sqrt_start),
		.sqrt_radicand (sqrt_radicand),
		.sqrt_busy     (sqrt_busy),
		.sqrt_root     (sqrt_root),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.display_value (display_value),
		.display_write (display_write),
		.led_red       (led_red),
		.low_power     (low_power),
		.phase         (phase)
	);

endmodule

// File: dv/fipm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fipm_checker
// Watches the configuration port and both transfer channels of the fall
// impact peak monitor. It keeps its own copy of the monitor's state, works
// out the result of every tick it sees go in, and compares each result
// transfer field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module fipm_checker
	import fipm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 free_fall,
	input  logic [AccelW-1:0]    accel_value,
	input  logic                 key_press,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [RootW-1:0]     display_value,
	input  logic                 display_write,
	input  logic                 led_red,
	input  logic                 low_power,
	input  logic [1:0]           phase,
	output int                   pending_results,
	output int                   error_count,
	output int                   results_checked,
	output int                   impacts_shown
);

	typedef struct packed {
		logic [RootW-1:0] value;
		logic             write;
		logic             led;
		logic             low_pwr;
		phase_t           ph;
	} readout_t;

	// Register copies.
	logic [ThreshW-1:0] thr;
	logic [ImpactW-1:0] itk;
	logic [HoldW-1:0]   htk;
	logic [BlinkW-1:0]  bhp;

	// Monitor state.
	phase_t             ph;
	logic [ImpactW-1:0] above_cnt;
	logic               hit;
	logic [HoldW-1:0]   hold_cnt;
	logic [BlinkW-1:0]  blink_cnt;
	logic [RootW-1:0]   peak;
	logic [RootW-1:0]   shown;
	logic               trk;
	logic               blk;
	logic               hld;
	logic               led;

	readout_t expected_readouts[$];
	readout_t predicted;
	readout_t want;

	function automatic logic [RootW-1:0] int_root(input logic [AccelW-1:0] x);
		logic [RootW-1:0] r;
		int unsigned      t;
		r = '0;
		for (int b = RootW - 1; b >= 0; b--) begin
			t = r | (32'd1 << b);
			if (t * t <= x)
				r = t[RootW-1:0];
		end
		return r;
	endfunction

	task automatic reset_monitor();
		thr       = ThreshReset;
		itk       = ImpactReset;
		htk       = HoldReset;
		bhp       = BlinkReset;
		ph        = PH_START;
		above_cnt = ImpactReset;
		hit       = 1'b0;
		hold_cnt  = HoldReset;
		blink_cnt = BlinkReset;
		peak      = '0;
		shown     = '0;
		trk       = 1'b0;
		blk       = 1'b0;
		hld       = 1'b0;
		led       = 1'b0;
	endtask

	// Advances the monitor by one tick and returns the readout it produces.
	task automatic step_tick(input logic ff, input logic [AccelW-1:0] acc, input logic kp,
			output readout_t r);
		logic [RootW-1:0] root;
		r = '0;
		// The impact counter only runs on ticks after blinking has started.
		if (blk) begin
			if (acc > thr) begin
				if (above_cnt != '0)
					above_cnt--;
			end else begin
				above_cnt = itk;
			end
			hit = (above_cnt == '0);
		end
		if (hld && hold_cnt != '0)
			hold_cnt--;
		if (trk) begin
			root = int_root(acc);
			if (root > peak)
				peak = root;
		end
		shown = peak;
		case (ph)
			PH_START: begin
				r.write = 1'b1;
				ph      = PH_ARMED;
			end
			PH_ARMED: begin
				if (ff)
					ph = PH_FALLING;
			end
			PH_FALLING: begin
				trk = 1'b1;
				blk = 1'b1;
				if (hit) begin
					trk     = 1'b0;
					r.write = 1'b1;
					r.value = shown;
					ph      = PH_LANDED;
				end
			end
			default: begin
				hld = 1'b1;
				if (hold_cnt == '0 || kp) begin
					blk      = 1'b0;
					hld      = 1'b0;
					hold_cnt = htk;
					peak     = '0;
					hit      = 1'b0;
					r.write  = 1'b1;
					ph       = PH_ARMED;
				end
			end
		endcase
		if (blk) begin
			if (blink_cnt <= 1) begin
				led       = !led;
				blink_cnt = bhp;
			end else begin
				blink_cnt--;
			end
		end else begin
			led = 1'b0;
		end
		r.led     = led;
		r.low_pwr = (ph == PH_ARMED);
		r.ph      = ph;
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			error_count++;
			$error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_monitor();
			expected_readouts.delete();
			pending_results = 0;
			error_count     = 0;
			results_checked = 0;
			impacts_shown   = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_IMPACT_THRESHOLD: thr = cfg_data[ThreshW-1:0];
					REG_IMPACT_TICKS:     itk = cfg_data[ImpactW-1:0];
					REG_HOLD_TICKS:       htk = cfg_data[HoldW-1:0];
					REG_BLINK_HALF:       bhp = cfg_data[BlinkW-1:0];
					default: ;
				endcase
			end
			// A result can never belong to a tick taken at the same edge, so the
			// output side is handled first.
			if (out_valid && out_ready) begin
				if (expected_readouts.size() == 0) begin
					error_count++;
					$error("result transfer with no tick outstanding: display_value %0d, phase %0d",
						display_value, phase);
				end else begin
					want = expected_readouts.pop_front();
					check_field("display_value", want.value, display_value);
					check_field("display_write", want.write, display_write);
					check_field("led_red", want.led, led_red);
					check_field("low_power", want.low_pwr, low_power);
					check_field("phase", want.ph, phase);
					results_checked++;
				end
			end
			if (in_valid && in_ready) begin
				step_tick(free_fall, accel_value, key_press, predicted);
				if (predicted.write && predicted.ph == PH_LANDED)
					impacts_shown++;
				expected_readouts.push_back(predicted);
			end
			pending_results = expected_readouts.size();
		end
	end

endmodule

// File: dv/fall_impact_peak_monitor_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fall_impact_peak_monitor_top_tb
// Drives ticks into the fall impact peak monitor: a directed opening through
// every phase and corner setting, a long fall that brings the LED timer to
// its first reload, then random fall episodes under changing settings, with
// random gaps on both channels. The checker beside the block does the
// prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module fall_impact_peak_monitor_top_tb;
	import fipm_pkg::*;

	localparam int SoakTicks    = 500;
	localparam int EpisodeTicks = 400;
	localparam int RoundTicks   = 60;
	localparam int SettleCycles = 24;
	localparam int StallLimit   = 5000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CfgIndexW-1:0] cfg_index;
	logic [CfgDataW-1:0]  cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 free_fall;
	logic [AccelW-1:0]    accel_value;
	logic                 key_press;
	logic                 out_valid;
	logic                 out_ready;
	logic [RootW-1:0]     display_value;
	logic                 display_write;
	logic                 led_red;
	logic                 low_power;
	logic [1:0]           phase;

	int pending_results;
	int error_count;
	int results_checked;
	int impacts_shown;

	int                 ticks_sent;
	int                 settings_written;
	logic               steady;
	logic [ThreshW-1:0] cur_th;
	logic [ImpactW-1:0] cur_it;
	logic [HoldW-1:0]   cur_ht;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	fall_impact_peak_monitor_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.free_fall     (free_fall),
		.accel_value   (accel_value),
		.key_press     (key_press),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.display_value (display_value),
		.display_write (display_write),
		.led_red       (led_red),
		.low_power     (low_power),
		.phase         (phase)
	);

	fipm_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.free_fall       (free_fall),
		.accel_value     (accel_value),
		.key_press       (key_press),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.display_value   (display_value),
		.display_write   (display_write),
		.led_red         (led_red),
		.low_power       (low_power),
		.phase           (phase),
		.pending_results (pending_results),
		.error_count     (error_count),
		.results_checked (results_checked),
		.impacts_shown   (impacts_shown)
	);

	// Mostly no gap, sometimes a short one, rarely a long one; never one while steady is set.
	function automatic int idle_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (steady || sel < 55)
			return 0;
		if (sel < 90)
			return $urandom_range(1, 3);
		if (sel < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [AccelW-1:0] any_accel();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return $urandom_range(0, 1023);
			default: return $urandom_range(0, 20'hFFFFF);
		endcase
	endfunction

	function automatic logic [AccelW-1:0] quiet_accel();
		if ($urandom_range(0, 3) == 0)
			return cur_th;
		return $urandom_range(0, cur_th);
	endfunction

	function automatic logic [AccelW-1:0] loud_accel();
		if (cur_th == '1)
			return any_accel();
		case ($urandom_range(0, 3))
			0:       return cur_th + 1'b1;
			1:       return '1;
			default: return $urandom_range(32'(cur_th) + 1, 20'hFFFFF);
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic push_tick(input logic ff, input logic [AccelW-1:0] acc, input logic kp);
		int gap;
		gap = idle_gap();
		repeat (gap) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		free_fall   <= ff;
		accel_value <= acc;
		key_press   <= kp;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		ticks_sent++;
	endtask

	task automatic push_noise();
		push_tick($urandom_range(0, 1), any_accel(), $urandom_range(0, 1));
	endtask

	// Holds the sender until every predicted result has been taken.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic apply_settings(input logic [ThreshW-1:0] th, input logic [ImpactW-1:0] it,
			input logic [HoldW-1:0] ht, input logic [BlinkW-1:0] bh);
		cfg_we    <= 1'b1;
		cfg_index <= REG_IMPACT_THRESHOLD;
		cfg_data  <= CfgDataW'(th);
		@(negedge clk);
		cfg_index <= REG_IMPACT_TICKS;
		cfg_data  <= CfgDataW'(it);
		@(negedge clk);
		cfg_index <= REG_HOLD_TICKS;
		cfg_data  <= CfgDataW'(ht);
		@(negedge clk);
		cfg_index <= REG_BLINK_HALF;
		cfg_data  <= CfgDataW'(bh);
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_th = th;
		cur_it = it;
		cur_ht = ht;
		settings_written++;
	endtask

	// One arm, fall, impact and landing sequence with random content.
	task automatic run_episode();
		int n;
		int spike;
		n = $urandom_range(0, 3);
		repeat (n) push_tick(1'b0, any_accel(), $urandom_range(0, 15) == 0);
		push_tick(1'b1, any_accel(), $urandom_range(0, 1));
		n = $urandom_range(0, 5);
		repeat (n) push_tick($urandom_range(0, 1), quiet_accel(), 1'b0);
		if ($urandom_range(0, 3) == 0) begin
			spike = $urandom_range(1, (cur_it == 0) ? 1 : cur_it);
			repeat (spike) push_tick($urandom_range(0, 1), loud_accel(), 1'b0);
			push_tick($urandom_range(0, 1), quiet_accel(), 1'b0);
		end
		n = cur_it + $urandom_range(0, 2);
		repeat (n) push_tick($urandom_range(0, 1), loud_accel(), 1'b0);
		if ($urandom_range(0, 3) == 0)
			n = $urandom_range(0, (cur_ht + 2 > 40) ? 40 : cur_ht + 2);
		else
			n = $urandom_range(0, 4);
		repeat (n) push_tick($urandom_range(0, 1), any_accel(), 1'b0);
		if ($urandom_range(0, 9) < 7)
			push_tick($urandom_range(0, 1), any_accel(), 1'b1);
	endtask

	task automatic run_round(input int count);
		int round_end;
		round_end = ticks_sent + count;
		while (ticks_sent < round_end) begin
			if ($urandom_range(0, 99) < 15)
				push_noise();
			else
				run_episode();
		end
	endtask

	// Result side: bursts of ready with random stalls between them.
	initial begin
		int run;
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 4) == 0)
				run = $urandom_range(40, 120);
			else
				run = $urandom_range(1, 12);
			out_ready <= 1'b1;
			repeat (run) @(negedge clk);
			stall = idle_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
		end
	end

	// Ends the run if neither channel moves for too long.
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < StallLimit) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("Timed out with %0d results outstanding.", pending_results);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int round;
		int stop_at;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = REG_IMPACT_THRESHOLD;
		cfg_data         = '0;
		in_valid         = 1'b0;
		free_fall        = 1'b0;
		accel_value      = '0;
		key_press        = 1'b0;
		ticks_sent       = 0;
		settings_written = 0;
		steady           = 1'b0;
		cur_th           = ThreshReset;
		cur_it           = ImpactReset;
		cur_ht           = HoldReset;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: start, key while armed, full-scale peak, a reload at
		// exactly the threshold, then an impact and a key rearm.
		push_tick(1'b0, '0, 1'b0);
		push_tick(1'b0, '1, 1'b1);
		push_tick(1'b1, '0, 1'b0);
		push_tick(1'b0, '1, 1'b0);
		push_tick(1'b0, '1, 1'b0);
		push_tick(1'b0, ThreshReset, 1'b0);
		repeat (6) push_tick(1'b0, ThreshReset + 1'b1, 1'b0);
		push_tick(1'b0, 20'd1, 1'b0);
		push_tick(1'b0, '0, 1'b1);

		// Zero impact ticks, zero hold and zero blink period, with a zero
		// threshold so that any nonzero sample counts.
		wait_idle();
		apply_settings('0, '0, '0, '0);
		push_tick(1'b1, 20'd7, 1'b0);
		repeat (3) push_tick(1'b0, '0, 1'b0);
		push_tick(1'b0, '0, 1'b1);
		push_tick(1'b1, 20'd3, 1'b0);
		repeat (5) push_tick(1'b0, '0, 1'b0);

		// A long fall that can never land, so the LED timer counts down from the value
		// that the earlier ticks left and reloads with the short period.
		wait_idle();
		apply_settings('1, 4'd15, 14'd16383, 10'd1);
		repeat (3) push_tick(1'b1, any_accel(), 1'b1);
		stop_at = ticks_sent + SoakTicks;
		while (ticks_sent < stop_at)
			push_noise();

		stop_at = ticks_sent + EpisodeTicks;
		round = 1;
		while (ticks_sent < stop_at) begin
			wait_idle();
			steady = (round % 3 == 0);
			case (round % 4)
				1: apply_settings($urandom_range(0, 200000), 4'd1, 14'd1,
					$urandom_range(0, 1));
				2: apply_settings($urandom_range(0, 20'hFFFFF), $urandom_range(1, 15),
					$urandom_range(1, 30), $urandom_range(1, 6));
				3: apply_settings($urandom_range(0, 20000), $urandom_range(0, 4), '0, 10'd2);
				default: apply_settings($urandom_range(0, 20'hFFFFF), $urandom_range(1, 8),
					($urandom_range(0, 1) == 0) ? 14'd16383 : $urandom_range(1, 60),
					$urandom_range(0, 3));
			endcase
			run_round(RoundTicks);
			round++;
		end

		// Largest impact count, hold and blink period last, since the blink
		// reload freezes the LED for the rest of the run.
		wait_idle();
		steady = 1'b0;
		apply_settings($urandom_range(0, 20'hFFFFF), 4'd15, 14'd16383, 10'd1023);
		run_round(40);

		wait_idle();
		$display("Sent %0d ticks under %0d register settings; %0d results compared.",
			ticks_sent, settings_written, results_checked);
		$display("Impacts shown on the display: %0d, mismatches: %0d.",
			impacts_shown, error_count);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
